/* rtl/core/pipe_ring_buffer_engine_defines.svh */
// Assertion macros shared by the pipe ring buffer engine modules.
`ifndef PIPE_RING_BUFFER_ENGINE_DEFINES_SVH
`define PIPE_RING_BUFFER_ENGINE_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define PRBE_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition is followed in the next cycle by a consequence.
`define PRBE_ASSERT_NEXT(label, clk, rstn, cond, nxt, msg) \
  `PRBE_ASSERT(label, clk, rstn, (cond) |=> (nxt), msg)

`endif

/* rtl/core/prbe_pkg.sv */
// Shared types and constants of the pipe ring buffer engine.
package prbe_pkg;

  localparam int CAPACITY    = 4096;
  localparam int PtrW        = $clog2(CAPACITY);
  localparam int CntW        = $clog2(CAPACITY + 1);
  localparam int CountW      = 16;
  localparam int ByteW       = 8;
  localparam int EndsW       = 8;
  localparam int MaskW       = 4;
  localparam int OpW         = 3;
  localparam int StatusW     = 3;
  localparam int CmpW        = (CntW > CountW) ? CntW : CountW;
  localparam int LimitW      = 13;
  localparam logic [LimitW-1:0] LimitReset = LimitW'(512);

  // Stream payload layout
  localparam int InDataBits  = CountW + ByteW + 1;
  localparam int InDataW     = ((InDataBits + 7) / 8) * 8;
  localparam int OutDataBits = ByteW + CntW + CntW + MaskW;
  localparam int OutDataW    = ((OutDataBits + 7) / 8) * 8;

  // Poll mask bit positions
  localparam int PollReadable = 0;
  localparam int PollHangup   = 1;
  localparam int PollWritable = 2;
  localparam int PollError    = 3;

  typedef enum logic [OpW-1:0] {
    OP_WR_START = 3'd0,
    OP_WR_DATA  = 3'd1,
    OP_RD_BYTE  = 3'd2,
    OP_OPEN     = 3'd3,
    OP_CLOSE    = 3'd4,
    OP_POLL     = 3'd5
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 3'd0,
    ST_BLOCK   = 3'd1,
    ST_BROKEN  = 3'd2,
    ST_EOF     = 3'd3,
    ST_NOGRANT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RESP = 2'd2
  } state_e;

  typedef struct packed {
    logic load;    // capture the input transaction
    logic exec;    // apply the captured operation
    logic cfg_wr;  // write the atomic limit
  } cmd_t;

endpackage

/* rtl/core/prbe_ctrl.sv */
// Handshake controller: sequences capture, execute and response.
`include "pipe_ring_buffer_engine_defines.svh"

module prbe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  output logic            m_tvalid_o,
  input  logic            m_tready_i,
  input  logic            cfg_valid_i,
  output prbe_pkg::cmd_t  cmd_o
);

  prbe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prbe_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    s_tready_o   = 1'b0;
    m_tvalid_o   = 1'b0;
    cmd_o.load   = 1'b0;
    cmd_o.exec   = 1'b0;
    cmd_o.cfg_wr = cfg_valid_i;
    unique case (state_q)
      prbe_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = prbe_pkg::S_EXEC;
        end
      end
      prbe_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = prbe_pkg::S_RESP;
      end
      prbe_pkg::S_RESP: begin
        m_tvalid_o = 1'b1;
        if (m_tready_i) begin
          state_d = prbe_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prbe_pkg::S_IDLE;
      end
    endcase
  end

  `PRBE_ASSERT(a_one_in_flight, clk_i, rst_ni, !(s_tready_o && m_tvalid_o), "accepting while a result is pending")
  `PRBE_ASSERT_NEXT(a_accept_exec, clk_i, rst_ni, s_tvalid_i && s_tready_o, cmd_o.exec, "accepted transaction not executed")

endmodule

/* rtl/core/prbe_dpath.sv */
// Datapath: byte store, pointers, end counts, grant and result registers.
`include "pipe_ring_buffer_engine_defines.svh"

module prbe_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  prbe_pkg::cmd_t                     cmd_i,
  input  logic [prbe_pkg::LimitW-1:0]        cfg_data_i,
  input  logic [prbe_pkg::OpW-1:0]           op_i,
  input  logic [prbe_pkg::CountW-1:0]        count_i,
  input  logic [prbe_pkg::ByteW-1:0]         data_byte_i,
  input  logic                               end_is_reader_i,
  output logic [prbe_pkg::StatusW-1:0]       status_o,
  output logic [prbe_pkg::ByteW-1:0]         read_byte_o,
  output logic [prbe_pkg::CntW-1:0]          granted_count_o,
  output logic [prbe_pkg::CntW-1:0]          used_count_o,
  output logic [prbe_pkg::MaskW-1:0]         poll_mask_o
);

  localparam int PtrW = prbe_pkg::PtrW;
  localparam int CntW = prbe_pkg::CntW;
  localparam int CmpW = prbe_pkg::CmpW;

  // Captured transaction
  prbe_pkg::op_e                 op_q;
  logic [prbe_pkg::CountW-1:0]   cnt_q;
  logic [prbe_pkg::ByteW-1:0]    byte_q;
  logic                          isrd_q;

  // Pipe state
  logic [PtrW-1:0]               rp_q, rp_d, wp_q, wp_d;
  logic                          full_q, full_d;
  logic [prbe_pkg::EndsW-1:0]    rends_q, rends_d, wends_q, wends_d;
  logic [CntW-1:0]               grant_q, grant_d;
  logic [prbe_pkg::LimitW-1:0]   limit_q;

  // Result registers
  prbe_pkg::status_e             status_q, status_d;
  logic [CntW-1:0]               granted_q, granted_d;
  logic [prbe_pkg::MaskW-1:0]    mask_q, mask_d;
  logic                          rdhit_q, rdhit_d;
  logic [prbe_pkg::ByteW-1:0]    rdata_q;

  logic [prbe_pkg::ByteW-1:0]    mem_q [prbe_pkg::CAPACITY];

  logic [CntW-1:0]               used, free;
  logic [PtrW-1:0]               wp_inc, rp_inc;
  logic                          mem_we, mem_re;

  always_comb begin
    if (full_q) begin
      used = CntW'(prbe_pkg::CAPACITY);
    end else if (wp_q >= rp_q) begin
      used = CntW'(wp_q) - CntW'(rp_q);
    end else begin
      used = CntW'(prbe_pkg::CAPACITY) + CntW'(wp_q) - CntW'(rp_q);
    end
    free = CntW'(prbe_pkg::CAPACITY) - used;
  end

  assign wp_inc = (wp_q == PtrW'(prbe_pkg::CAPACITY - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc = (rp_q == PtrW'(prbe_pkg::CAPACITY - 1)) ? '0 : rp_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= prbe_pkg::op_e'(op_i);
      cnt_q  <= count_i;
      byte_q <= data_byte_i;
      isrd_q <= end_is_reader_i;
    end
  end

  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    full_d    = full_q;
    rends_d   = rends_q;
    wends_d   = wends_q;
    grant_d   = grant_q;
    status_d  = prbe_pkg::ST_OK;
    granted_d = '0;
    mask_d    = '0;
    rdhit_d   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    unique case (op_q)
      prbe_pkg::OP_WR_START: begin
        if (cnt_q == '0) begin
          status_d = prbe_pkg::ST_OK;
        end else if (rends_q == '0) begin
          status_d = prbe_pkg::ST_BROKEN;
        end else if (cnt_q <= prbe_pkg::CountW'(limit_q)) begin
          if (CmpW'(free) >= CmpW'(cnt_q)) begin
            granted_d = CntW'(cnt_q);
          end else begin
            status_d = prbe_pkg::ST_BLOCK;
          end
        end else begin
          granted_d = (CmpW'(cnt_q) < CmpW'(free)) ? CntW'(cnt_q) : free;
          if (free == '0) begin
            status_d = prbe_pkg::ST_BLOCK;
          end
        end
        grant_d = granted_d;
      end
      prbe_pkg::OP_WR_DATA: begin
        if (grant_q == '0) begin
          status_d = prbe_pkg::ST_NOGRANT;
        end else if (full_q) begin
          status_d = prbe_pkg::ST_BLOCK;
        end else begin
          mem_we  = 1'b1;
          wp_d    = wp_inc;
          grant_d = grant_q - 1'b1;
          full_d  = (wp_inc == rp_q);
        end
      end
      prbe_pkg::OP_RD_BYTE: begin
        if (used == '0) begin
          status_d = (wends_q == '0) ? prbe_pkg::ST_EOF : prbe_pkg::ST_BLOCK;
        end else begin
          mem_re  = 1'b1;
          rdhit_d = 1'b1;
          rp_d    = rp_inc;
          full_d  = 1'b0;
        end
      end
      prbe_pkg::OP_OPEN: begin
        if (isrd_q) begin
          if (rends_q != '1) rends_d = rends_q + 1'b1;
        end else begin
          if (wends_q != '1) wends_d = wends_q + 1'b1;
        end
      end
      prbe_pkg::OP_CLOSE: begin
        if (isrd_q) begin
          if (rends_q != '0) rends_d = rends_q - 1'b1;
        end else begin
          if (wends_q != '0) wends_d = wends_q - 1'b1;
        end
        // Last end gone: drop all buffered bytes and any grant
        if (rends_d == '0 && wends_d == '0) begin
          rp_d    = '0;
          wp_d    = '0;
          full_d  = 1'b0;
          grant_d = '0;
        end
      end
      prbe_pkg::OP_POLL: begin
        if (isrd_q) begin
          if (used != '0) mask_d[prbe_pkg::PollReadable] = 1'b1;
          if (wends_q == '0) begin
            mask_d[prbe_pkg::PollReadable] = 1'b1;
            mask_d[prbe_pkg::PollHangup]   = 1'b1;
          end
        end else begin
          if (rends_q == '0) mask_d[prbe_pkg::PollError] = 1'b1;
          if (free != '0) mask_d[prbe_pkg::PollWritable] = 1'b1;
        end
      end
      default: begin
        status_d = prbe_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      full_q  <= 1'b0;
      rends_q <= '0;
      wends_q <= '0;
      grant_q <= '0;
      limit_q <= prbe_pkg::LimitReset;
    end else begin
      if (cmd_i.exec) begin
        rp_q    <= rp_d;
        wp_q    <= wp_d;
        full_q  <= full_d;
        rends_q <= rends_d;
        wends_q <= wends_d;
        grant_q <= grant_d;
      end
      if (cmd_i.cfg_wr) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      mask_q    <= mask_d;
      rdhit_q   <= rdhit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) begin
      mem_q[wp_q] <= byte_q;
    end
    if (cmd_i.exec && mem_re) begin
      rdata_q <= mem_q[rp_q];
    end
  end

  assign status_o        = status_q;
  assign read_byte_o     = rdhit_q ? rdata_q : '0;
  assign granted_count_o = granted_q;
  assign used_count_o    = used;
  assign poll_mask_o     = mask_q;

  `PRBE_ASSERT(a_full_ptrs, clk_i, rst_ni, !full_q || (wp_q == rp_q), "full flag set with pointers apart")
  `PRBE_ASSERT(a_grant_range, clk_i, rst_ni, grant_q <= CntW'(prbe_pkg::CAPACITY), "grant exceeds capacity")

endmodule

/* rtl/core/pipe_ring_buffer_engine.sv */
// Top level of the pipe ring buffer engine: byte pipe over a circular store.
//
// Usage:
//   s_axis carries one operation per transaction: tuser holds the operation
//   code (write start, write data, read byte, open end, close end, poll),
//   tdata holds count, data byte and the end selector. m_axis returns one
//   result per operation: tuser holds the status, tdata the read byte,
//   granted count, bytes held after the operation and the poll mask.
//   cfg carries the atomic write limit; it is always ready. The user must write
//   it only while no operation is in flight; the block does not enforce this.
// Sequencing:
//   An accepted input is captured, executed in the next state and then
//   presented on m_axis_tvalid_o; the block is ready for the next input in
//   the cycle after the result is accepted, so it takes no new operation
//   while one is in flight. The byte store has a registered read port.
// Reset:
//   Pointers, full flag, end counts and grant clear; the limit returns to
//   512. The byte store is not cleared, so no sweep is needed after reset.
// Stall:
//   While m_axis_tready_i is low the result holds and no input is taken.
module pipe_ring_buffer_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [prbe_pkg::InDataW-1:0]        s_axis_tdata_i,  // count, data_byte, end_is_reader
  input  logic [prbe_pkg::OpW-1:0]            s_axis_tuser_i,  // operation
  // Result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [prbe_pkg::OutDataW-1:0]       m_axis_tdata_o,  // read_byte, granted_count,
                                                               // used_count, poll_mask
  output logic [prbe_pkg::StatusW-1:0]        m_axis_tuser_o,  // status
  // Configuration write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [prbe_pkg::LimitW-1:0]         cfg_data_i
);

  localparam int CountW = prbe_pkg::CountW;
  localparam int ByteW  = prbe_pkg::ByteW;

  prbe_pkg::cmd_t                 cmd;
  logic [ByteW-1:0]               read_byte;
  logic [prbe_pkg::CntW-1:0]      granted_count;
  logic [prbe_pkg::CntW-1:0]      used_count;
  logic [prbe_pkg::MaskW-1:0]     poll_mask;

  // Limit register takes a write in any cycle
  assign cfg_ready_o = 1'b1;

  prbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid_i),
    .s_tready_o  (s_axis_tready_o),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .cfg_valid_i (cfg_valid_i),
    .cmd_o       (cmd)
  );

  prbe_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_data_i      (cfg_data_i),
    .op_i            (s_axis_tuser_i),
    .count_i         (s_axis_tdata_i[CountW-1:0]),
    .data_byte_i     (s_axis_tdata_i[CountW+ByteW-1:CountW]),
    .end_is_reader_i (s_axis_tdata_i[CountW+ByteW]),
    .status_o        (m_axis_tuser_o),
    .read_byte_o     (read_byte),
    .granted_count_o (granted_count),
    .used_count_o    (used_count),
    .poll_mask_o     (poll_mask)
  );

  // Pack the result fields from the lowest bit up; pad to whole bytes
  assign m_axis_tdata_o = prbe_pkg::OutDataW'({poll_mask, used_count, granted_count, read_byte});

endmodule

/* bench/tb_pipe_ring_buffer_engine.sv */
// Self-checking testbench of the pipe ring buffer engine: stream stimulus and result prediction.
module tb_pipe_ring_buffer_engine;

  localparam int OpW      = prbe_pkg::OpW;
  localparam int CountW   = prbe_pkg::CountW;
  localparam int ByteW    = prbe_pkg::ByteW;
  localparam int StatusW  = prbe_pkg::StatusW;
  localparam int CntW     = prbe_pkg::CntW;
  localparam int MaskW    = prbe_pkg::MaskW;
  localparam int LimitW   = prbe_pkg::LimitW;
  localparam int InDataW  = prbe_pkg::InDataW;
  localparam int OutDataW = prbe_pkg::OutDataW;
  localparam int Capacity = prbe_pkg::CAPACITY;

  // Operation codes the block ignores.
  localparam logic [OpW-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OpW-1:0] OP_RSVD_7 = 3'd7;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles without any transaction
  localparam int unsigned SETTLE_CYCLES = 8;   // quiet time after the last result
  localparam int unsigned MAX_ENDS = 255;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [CountW-1:0] count;
    logic [ByteW-1:0]  data;
    logic              is_reader;
  } pipe_req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   rbyte;
    logic [CntW-1:0]    granted;
    logic [CntW-1:0]    used;
    logic [MaskW-1:0]   mask;
  } pipe_rsp_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [OpW-1:0]      s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatusW-1:0]  m_axis_tuser_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [LimitW-1:0]   cfg_data_i = '0;

  pipe_ring_buffer_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the pipe state.
  logic [ByteW-1:0] shadow_bytes [Capacity];
  int unsigned      rd_ptr = 0;
  int unsigned      wr_ptr = 0;
  bit               pipe_full = 1'b0;
  int unsigned      reader_cnt = 0;
  int unsigned      writer_cnt = 0;
  int unsigned      grant_left = 0;
  int unsigned      limit_shadow = prbe_pkg::LimitReset;

  pipe_req_t   pending_ops [$];
  pipe_rsp_t   expected_results [$];
  int unsigned queued_ops = 0;
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 49;
  int unsigned idle_cycles = 0;

  pipe_req_t   presented_req;
  pipe_rsp_t   predicted_rsp;
  pipe_rsp_t   want_rsp;
  pipe_rsp_t   got_rsp;

  function automatic int unsigned held_bytes();
    if (pipe_full) return Capacity;
    if (wr_ptr >= rd_ptr) return wr_ptr - rd_ptr;
    return Capacity + wr_ptr - rd_ptr;
  endfunction

  // Advance the shadow state by one operation and return its result.
  function automatic pipe_rsp_t apply_pipe_op(input pipe_req_t rq);
    pipe_rsp_t   rs;
    int unsigned room;
    int unsigned give;
    rs = '0;
    rs.status = prbe_pkg::ST_OK;
    case (rq.op)
      prbe_pkg::OP_WR_START: begin
        room = Capacity - held_bytes();
        give = 0;
        if (rq.count != 0) begin
          if (reader_cnt == 0) begin
            rs.status = prbe_pkg::ST_BROKEN;
          end else if (rq.count <= limit_shadow) begin
            // all-or-nothing up to and including the atomic limit
            if (room >= rq.count) give = rq.count;
            else rs.status = prbe_pkg::ST_BLOCK;
          end else begin
            give = (rq.count < room) ? rq.count : room;
            if (give == 0) rs.status = prbe_pkg::ST_BLOCK;
          end
        end
        grant_left = give;
        rs.granted = CntW'(give);
      end
      prbe_pkg::OP_WR_DATA: begin
        if (grant_left == 0) begin
          rs.status = prbe_pkg::ST_NOGRANT;
        end else if (pipe_full) begin
          rs.status = prbe_pkg::ST_BLOCK;
        end else begin
          shadow_bytes[wr_ptr] = rq.data;
          wr_ptr = (wr_ptr + 1) % Capacity;
          grant_left--;
          if (wr_ptr == rd_ptr) pipe_full = 1'b1;
        end
      end
      prbe_pkg::OP_RD_BYTE: begin
        if (held_bytes() == 0) begin
          rs.status = (writer_cnt == 0) ? prbe_pkg::ST_EOF : prbe_pkg::ST_BLOCK;
        end else begin
          rs.rbyte = shadow_bytes[rd_ptr];
          rd_ptr = (rd_ptr + 1) % Capacity;
          pipe_full = 1'b0;
        end
      end
      prbe_pkg::OP_OPEN: begin
        if (rq.is_reader) begin
          if (reader_cnt < MAX_ENDS) reader_cnt++;
        end else begin
          if (writer_cnt < MAX_ENDS) writer_cnt++;
        end
      end
      prbe_pkg::OP_CLOSE: begin
        if (rq.is_reader) begin
          if (reader_cnt != 0) reader_cnt--;
        end else begin
          if (writer_cnt != 0) writer_cnt--;
        end
        // last end gone: the pipe empties
        if (reader_cnt == 0 && writer_cnt == 0) begin
          rd_ptr = 0;
          wr_ptr = 0;
          pipe_full = 1'b0;
          grant_left = 0;
        end
      end
      prbe_pkg::OP_POLL: begin
        if (rq.is_reader) begin
          if (held_bytes() != 0) rs.mask[prbe_pkg::PollReadable] = 1'b1;
          if (writer_cnt == 0) begin
            rs.mask[prbe_pkg::PollReadable] = 1'b1;
            rs.mask[prbe_pkg::PollHangup] = 1'b1;
          end
        end else begin
          if (reader_cnt == 0) rs.mask[prbe_pkg::PollError] = 1'b1;
          if (held_bytes() != Capacity) rs.mask[prbe_pkg::PollWritable] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rs.used = CntW'(held_bytes());
    return rs;
  endfunction

  function automatic void check_field(input string fname, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      fail_count++;
    end
  endfunction

  // Driver: present queued operations, predict each one as its transaction completes.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted_rsp = apply_pipe_op(presented_req);
        expected_results.push_back(predicted_rsp);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          presented_req = pending_ops.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= InDataW'({presented_req.is_reader, presented_req.data,
                                      presented_req.count});
          s_axis_tuser_i <= presented_req.op;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_rsp.status = m_axis_tuser_o;
        got_rsp.rbyte = m_axis_tdata_o[0 +: ByteW];
        got_rsp.granted = m_axis_tdata_o[ByteW +: CntW];
        got_rsp.used = m_axis_tdata_o[ByteW + CntW +: CntW];
        got_rsp.mask = m_axis_tdata_o[ByteW + 2 * CntW +: MaskW];
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, got_rsp);
          fail_count++;
        end else begin
          want_rsp = expected_results.pop_front();
          check_field("status", want_rsp.status, got_rsp.status);
          check_field("read_byte", want_rsp.rbyte, got_rsp.rbyte);
          check_field("granted_count", want_rsp.granted, got_rsp.granted);
          check_field("used_count", want_rsp.used, got_rsp.used);
          check_field("poll_mask", want_rsp.mask, got_rsp.mask);
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("pipe_ring_buffer_engine regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_op(input logic [OpW-1:0] op, input int unsigned cnt,
                          input int unsigned b, input int unsigned rd);
    pipe_req_t rq;
    rq.op = op;
    rq.count = CountW'(cnt);
    rq.data = ByteW'(b);
    rq.is_reader = rd[0];
    pending_ops.push_back(rq);
    if (op <= prbe_pkg::OP_POLL) queued_ops++;
  endtask

  // Hold off until the block has returned every result and gone quiet.
  task automatic wait_idle();
    while (pending_ops.size() != 0 || s_axis_tvalid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_shadow = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: write grants followed by their data, read runs, polls,
  // end bookkeeping, with some broken bursts and raw noise mixed in.
  task automatic random_traffic(input int unsigned target);
    int unsigned stop_at;
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    int          lo;
    stop_at = queued_ops + target;
    while (queued_ops < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 9))
          0: n = 0;
          1: n = $urandom_range(0, 65535);
          2: n = 65535;
          3: begin
            lo = int'(limit_shadow) - 2;
            n = (lo < 1) ? $urandom_range(1, 3) : $urandom_range(lo, lo + 4);
          end
          default: n = $urandom_range(1, 48);
        endcase
        queue_op(prbe_pkg::OP_WR_START, n, $urandom, $urandom);
        k = (n > 48) ? $urandom_range(1, 48) : n;
        // overrun or abandon the grant now and then
        if ($urandom_range(0, 6) == 0) k = k + $urandom_range(1, 3);
        else if (k != 0 && $urandom_range(0, 6) == 0) k = $urandom_range(0, k - 1);
        repeat (k) queue_op(prbe_pkg::OP_WR_DATA, $urandom, $urandom, $urandom);
      end else if (pick < 60) begin
        repeat ($urandom_range(1, 40))
          queue_op(prbe_pkg::OP_RD_BYTE, $urandom, $urandom, $urandom);
      end else if (pick < 70) begin
        queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, $urandom);
      end else if (pick < 84) begin
        queue_op(($urandom_range(0, 99) < 58) ? prbe_pkg::OP_OPEN : prbe_pkg::OP_CLOSE,
                 $urandom, $urandom, $urandom);
      end else if (pick < 88) begin
        // close each side six times, which may tear the pipe down, then reopen both ends
        repeat (6) queue_op(prbe_pkg::OP_CLOSE, $urandom, $urandom, 1);
        repeat (6) queue_op(prbe_pkg::OP_CLOSE, $urandom, $urandom, 0);
        queue_op(prbe_pkg::OP_RD_BYTE, $urandom, $urandom, $urandom);
        queue_op(prbe_pkg::OP_OPEN, $urandom, $urandom, 1);
        queue_op(prbe_pkg::OP_OPEN, $urandom, $urandom, 0);
      end else begin
        queue_op(OpW'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
      end
    end
  endtask

  // Part-fill the store, probe it, drain it, then saturate the writer end count.
  task automatic fill_and_saturate();
    queue_op(prbe_pkg::OP_OPEN, $urandom, $urandom, 1);
    queue_op(prbe_pkg::OP_OPEN, $urandom, $urandom, 0);
    queue_op(prbe_pkg::OP_WR_START, 65535, $urandom, $urandom);
    repeat (40) queue_op(prbe_pkg::OP_WR_DATA, $urandom, $urandom, $urandom);
    queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, 0);
    queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, 1);
    queue_op(prbe_pkg::OP_WR_START, 1, $urandom, $urandom);
    queue_op(prbe_pkg::OP_WR_START, 5, $urandom, $urandom);
    queue_op(prbe_pkg::OP_WR_START, 3, $urandom, $urandom);
    repeat (3) queue_op(prbe_pkg::OP_WR_DATA, $urandom, $urandom, $urandom);
    queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, 0);
    repeat (48) queue_op(prbe_pkg::OP_RD_BYTE, $urandom, $urandom, $urandom);
    repeat (MAX_ENDS + 5) queue_op(prbe_pkg::OP_OPEN, $urandom, $urandom, 0);
    queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, 1);
    repeat (3) queue_op(prbe_pkg::OP_CLOSE, $urandom, $urandom, 0);
    queue_op(prbe_pkg::OP_RD_BYTE, $urandom, $urandom, $urandom);
    queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, 1);
    queue_op(prbe_pkg::OP_POLL, $urandom, $urandom, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening with the reset limit: closed pipe, grants, replacement, drain.
    queue_op(prbe_pkg::OP_RD_BYTE, 0, 0, 0);          // empty, no writers: end of file
    queue_op(prbe_pkg::OP_POLL, 65535, 255, 1);
    queue_op(prbe_pkg::OP_POLL, 0, 0, 0);
    queue_op(prbe_pkg::OP_WR_START, 5, 0, 0);         // no readers: broken pipe
    queue_op(prbe_pkg::OP_WR_DATA, 0, 8'h5a, 0);      // data without grant
    queue_op(prbe_pkg::OP_CLOSE, 0, 0, 1);            // close at zero ends
    queue_op(prbe_pkg::OP_OPEN, 0, 0, 0);
    queue_op(prbe_pkg::OP_OPEN, 0, 0, 1);
    queue_op(prbe_pkg::OP_WR_START, 0, 8'hff, 1);     // zero count
    queue_op(prbe_pkg::OP_WR_START, 513, 0, 0);       // above the limit: partial path
    queue_op(prbe_pkg::OP_WR_START, 3, 0, 0);         // replaces the old grant
    queue_op(prbe_pkg::OP_WR_DATA, 65535, 8'h00, 1);
    queue_op(prbe_pkg::OP_WR_DATA, 0, 8'hff, 0);
    queue_op(prbe_pkg::OP_WR_DATA, 0, 8'ha5, 0);
    queue_op(prbe_pkg::OP_WR_DATA, 0, 8'h3c, 0);      // grant used up
    repeat (4) queue_op(prbe_pkg::OP_RD_BYTE, 0, 0, 0);  // last one would block
    queue_op(OP_RSVD_6, 65535, 8'hff, 1);
    queue_op(OP_RSVD_7, 12345, 8'h81, 0);
    queue_op(prbe_pkg::OP_CLOSE, 0, 0, 0);
    queue_op(prbe_pkg::OP_RD_BYTE, 0, 0, 0);          // readers open, writers gone
    queue_op(prbe_pkg::OP_WR_START, 65535, 0, 0);
    queue_op(prbe_pkg::OP_CLOSE, 0, 0, 1);            // both ends gone: pipe clears

    // Receiver idles more than the sender.
    wait_idle();
    write_limit(LimitW'(Capacity));
    random_traffic(250);

    // Sender idles more than the receiver.
    wait_idle();
    send_idle_pct = 49;
    recv_idle_pct = 34;
    write_limit('0);
    random_traffic(250);

    // No idling from here on.
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(LimitW'($urandom_range(1, 700)));
    random_traffic(250);

    wait_idle();
    write_limit(LimitW'(Capacity));
    fill_and_saturate();

    wait_idle();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("pipe_ring_buffer_engine regression: pass");
    end else begin
      $display("pipe_ring_buffer_engine regression: fail");
    end
    $finish;
  end

endmodule
